[src/wbcd_pkg.sv]
// ----------------------------------------------------------------------------
// wbcd_pkg
// Shared types and constants for the base-w digit splitter with checksum.
// ----------------------------------------------------------------------------
package wbcd_pkg;

  // Widths fixed by the register and field definitions.
  localparam int unsigned ByteW      = 8;
  localparam int unsigned SelW       = 2;
  localparam int unsigned MsgCntW    = 10;
  localparam int unsigned CsumCntW   = 5;
  localparam int unsigned SumW       = 17;
  localparam int unsigned ShiftW     = 7;
  localparam int unsigned BitsW      = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 10;
  localparam int unsigned MaxCsumDig = 16;

  // Default for the largest message digit count.
  localparam int unsigned MaxMessageDigitsDef = 512;

  // Queue between the front and the back.
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  // Register reset values.
  localparam logic [SelW-1:0]     WidthSelRst  = SelW'(2);
  localparam logic [MsgCntW-1:0]  MsgDigitsRst = MsgCntW'(64);
  localparam logic [CsumCntW-1:0] CsumDigitsRst = CsumCntW'(3);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH_SEL   = 2'd0,
    CFG_MSG_DIGITS  = 2'd1,
    CFG_CSUM_DIGITS = 2'd2
  } wbcd_cfg_idx_e;

  // Current configuration as seen by the back end.
  typedef struct packed {
    logic [SelW-1:0]     width_sel;
    logic [MsgCntW-1:0]  msg_digits;
    logic [CsumCntW-1:0] csum_digits;
  } wbcd_cfg_t;

  // Head of the byte queue.
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } wbcd_head_t;

  // Queue status for the top level.
  typedef struct packed {
    logic [FifoCntW-1:0] count;
    logic                full;
  } wbcd_fifo_stat_t;

endpackage

[src/wbcd_front.sv]
// ----------------------------------------------------------------------------
// wbcd_front
// Accepts message bytes and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module wbcd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [wbcd_pkg::ByteW-1:0] msg_byte_i,
  output wbcd_pkg::wbcd_head_t      head_o,
  input  logic                      pop_i,
  output wbcd_pkg::wbcd_fifo_stat_t stat_o
);
  import wbcd_pkg::*;

  logic [ByteW-1:0]    mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                push, pop;

  // A beat is taken whenever there is room in the queue.
  assign in_stall_o = (cnt_q == FifoCntW'(FifoDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Byte storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= msg_byte_i;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.data  = mem_q[rd_ptr_q];
  assign stat_o.count = cnt_q;
  assign stat_o.full  = in_stall_o;

endmodule

[src/wbcd_back.sv]
// ----------------------------------------------------------------------------
// wbcd_back
// Splits queued bytes into base-w digits, keeps the checksum and emits its
// digits after the last message digit, one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module wbcd_back #(
  parameter int unsigned MaxMessageDigits = wbcd_pkg::MaxMessageDigitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wbcd_pkg::wbcd_cfg_t           cfg_i,
  input  wbcd_pkg::wbcd_head_t          head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wbcd_pkg::ByteW-1:0]    digit_o,
  output logic [wbcd_pkg::MsgCntW-1:0]  position_o,
  output logic                          is_checksum_o,
  output logic                          last_o
);
  import wbcd_pkg::*;

  typedef enum logic {
    ST_MSG,
    ST_CSUM
  } state_e;

  state_e              state_q, state_d;
  logic [BitsW-1:0]    bits_q, bits_d;
  logic [MsgCntW-1:0]  cnt_q, cnt_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [ShiftW-1:0]   sh_q, sh_d;
  logic [MsgCntW-1:0]  pos_q, pos_d;
  logic [3:0]          csi_q, csi_d;
  logic                out_valid_q, out_valid_d;
  logic [ByteW-1:0]    digit_q, digit_d;
  logic [MsgCntW-1:0]  position_q, position_d;
  logic                is_cs_q, is_cs_d;
  logic                last_q, last_d;

  logic [BitsW-1:0]    lg;
  logic [ByteW-1:0]    mask;
  logic [MsgCntW-1:0]  md;
  logic [3:0]          cd_m1;
  logic [ShiftW-1:0]   sh_init;
  logic                advance;
  logic [BitsW-1:0]    nb;
  logic [ByteW-1:0]    msg_dig;
  logic [ByteW-1:0]    cs_dig;
  logic [MsgCntW:0]    cnt_inc;
  logic                cs_last;

  // Effective digit width and clamped counts.
  always_comb begin
    lg   = BitsW'(1) << cfg_i.width_sel;
    mask = ByteW'((9'd1 << lg) - 9'd1);
    if (cfg_i.msg_digits == '0) begin
      md = MsgCntW'(1);
    end else if (32'(cfg_i.msg_digits) > MaxMessageDigits) begin
      md = MsgCntW'(MaxMessageDigits);
    end else begin
      md = cfg_i.msg_digits;
    end
    if (cfg_i.csum_digits == '0) begin
      cd_m1 = '0;
    end else if (32'(cfg_i.csum_digits) > MaxCsumDig) begin
      cd_m1 = 4'(MaxCsumDig - 1);
    end else begin
      cd_m1 = 4'(cfg_i.csum_digits - 1'b1);
    end
    sh_init = ShiftW'({3'b000, cd_m1} << cfg_i.width_sel);
  end

  // Digit extraction for both phases.
  assign advance = !out_valid_q || !out_stall_i;
  assign nb      = bits_q - lg;
  assign msg_dig = (head_i.data >> nb) & mask;
  assign cs_dig  = (sh_q >= ShiftW'(SumW)) ? '0 : (ByteW'(sum_q >> sh_q) & mask);
  assign cnt_inc = {1'b0, cnt_q} + 1'b1;
  assign cs_last = (csi_q == cd_m1);

  // Next-state logic of the digit sequencer.
  always_comb begin
    state_d     = state_q;
    bits_d      = bits_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    sh_d        = sh_q;
    pos_d       = pos_q;
    csi_d       = csi_q;
    out_valid_d = out_valid_q;
    digit_d     = digit_q;
    position_d  = position_q;
    is_cs_d     = is_cs_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    if (advance) begin
      out_valid_d = 1'b0;
      unique case (state_q)
        ST_MSG: begin
          if (head_i.valid) begin
            if (cnt_q >= md) begin
              // Count already reached: the byte is dropped, checksum follows.
              pop_o   = 1'b1;
              bits_d  = BitsW'(ByteW);
              state_d = ST_CSUM;
              sh_d    = sh_init;
              pos_d   = md;
              csi_d   = '0;
            end else begin
              out_valid_d = 1'b1;
              digit_d     = msg_dig;
              position_d  = cnt_q;
              is_cs_d     = 1'b0;
              last_d      = 1'b0;
              sum_d       = sum_q + SumW'(mask - msg_dig);
              cnt_d       = cnt_inc[MsgCntW-1:0];
              if (cnt_inc >= {1'b0, md}) begin
                pop_o   = 1'b1;
                bits_d  = BitsW'(ByteW);
                state_d = ST_CSUM;
                sh_d    = sh_init;
                pos_d   = md;
                csi_d   = '0;
              end else if (nb < lg) begin
                pop_o  = 1'b1;
                bits_d = BitsW'(ByteW);
              end else begin
                bits_d = nb;
              end
            end
          end
        end
        ST_CSUM: begin
          out_valid_d = 1'b1;
          digit_d     = cs_dig;
          position_d  = pos_q;
          is_cs_d     = 1'b1;
          last_d      = cs_last;
          csi_d       = csi_q + 1'b1;
          sh_d        = sh_q - ShiftW'(lg);
          pos_d       = pos_q + 1'b1;
          if (cs_last) begin
            sum_d   = '0;
            cnt_d   = '0;
            state_d = ST_MSG;
          end
        end
        default: begin
          state_d = ST_MSG;
        end
      endcase
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_MSG;
      bits_q      <= BitsW'(ByteW);
      cnt_q       <= '0;
      sum_q       <= '0;
      sh_q        <= '0;
      pos_q       <= '0;
      csi_q       <= '0;
      out_valid_q <= 1'b0;
      digit_q     <= '0;
      position_q  <= '0;
      is_cs_q     <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      bits_q      <= bits_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      sh_q        <= sh_d;
      pos_q       <= pos_d;
      csi_q       <= csi_d;
      out_valid_q <= out_valid_d;
      digit_q     <= digit_d;
      position_q  <= position_d;
      is_cs_q     <= is_cs_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digit_o       = digit_q;
  assign position_o    = position_q;
  assign is_checksum_o = is_cs_q;
  assign last_o        = last_q;

endmodule

[src/wots_base_w_checksum_digits_top.sv]
// ----------------------------------------------------------------------------
// wots_base_w_checksum_digits_top
// Base-w digit splitter with running checksum for one-time signature chains.
// ----------------------------------------------------------------------------
// Message bytes enter through a two-beat queue and are split, most
// significant bits first, into digits of 1, 2, 4 or 8 bits; each digit leaves
// with its chain position, one result per cycle while the output is not
// stalled and bytes are queued. The byte that completes the message count is
// followed by the checksum digits, the last of which carries last. The
// sequencer's single output register sets this rate; the queue keeps taking
// bytes while a result is stalled, until it is full. Configuration is written
// with cfg_index_i and cfg_data_i only while the block is idle, a rule the
// user must keep; the block does not enforce it. Writes are always accepted.
module wots_base_w_checksum_digits_top #(
  parameter int unsigned MAX_MESSAGE_DIGITS = wbcd_pkg::MaxMessageDigitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [wbcd_pkg::ByteW-1:0]     msg_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [wbcd_pkg::ByteW-1:0]     digit_o,
  output logic [wbcd_pkg::MsgCntW-1:0]   position_o,
  output logic                           is_checksum_o,
  output logic                           last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wbcd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wbcd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import wbcd_pkg::*;

  wbcd_cfg_t       cfg_q, cfg_d;
  wbcd_head_t      head;
  wbcd_fifo_stat_t fifo_stat;
  logic            pop;
  logic [ByteW-1:0] cfg_mask;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (wbcd_cfg_idx_e'(cfg_index_i))
        CFG_WIDTH_SEL:   cfg_d.width_sel   = cfg_data_i[SelW-1:0];
        CFG_MSG_DIGITS:  cfg_d.msg_digits  = cfg_data_i[MsgCntW-1:0];
        CFG_CSUM_DIGITS: cfg_d.csum_digits = cfg_data_i[CsumCntW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_sel   <= WidthSelRst;
      cfg_q.msg_digits  <= MsgDigitsRst;
      cfg_q.csum_digits <= CsumDigitsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: byte queue.
  wbcd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .msg_byte_i (msg_byte_i),
    .head_o     (head),
    .pop_i      (pop),
    .stat_o     (fifo_stat)
  );

  // Back end: digit sequencer and output register.
  wbcd_back #(
    .MaxMessageDigits (MAX_MESSAGE_DIGITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digit_o       (digit_o),
    .position_o    (position_o),
    .is_checksum_o (is_checksum_o),
    .last_o        (last_o)
  );

  // Largest digit value for the current width.
  assign cfg_mask = ByteW'((9'd1 << (4'd1 << cfg_q.width_sel)) - 9'd1);

  // The final beat of a message always belongs to the checksum part.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> is_checksum_o)
    else $error("last flagged on a message digit");

  // A digit never exceeds w-1 while the width is unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && $stable(cfg_q.width_sel) |-> digit_o <= cfg_mask)
    else $error("digit wider than the configured width");

  // The queue never holds more beats than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.count <= FifoCntW'(FifoDepth))
    else $error("byte queue overfilled");

  // The queue refuses beats exactly when full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.full == (fifo_stat.count == FifoCntW'(FifoDepth)))
    else $error("queue stall out of step with fill level");

endmodule

[tb/wbcd_digit_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wbcd_digit_checker
// Watches the byte, digit and register channels of the base-w digit splitter,
// works out the digits and checksum that each accepted byte must produce, and
// compares every accepted result beat with the oldest digit still awaited.
// ----------------------------------------------------------------------------
module wbcd_digit_checker #(
  parameter int unsigned MAX_MESSAGE_DIGITS = wbcd_pkg::MaxMessageDigitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [wbcd_pkg::ByteW-1:0]     msg_byte_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [wbcd_pkg::ByteW-1:0]     digit_i,
  input  logic [wbcd_pkg::MsgCntW-1:0]   position_i,
  input  logic                           is_checksum_i,
  input  logic                           last_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [wbcd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [wbcd_pkg::CfgDataW-1:0]  cfg_data_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    pending_o
);
  import wbcd_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0]   digit;
    logic [MsgCntW-1:0] position;
    logic               is_checksum;
    logic               last;
  } chain_digit_t;

  // Our own copy of the registers and of the running message state.
  logic [SelW-1:0]     width_sel;
  logic [MsgCntW-1:0]  msg_digits;
  logic [CsumCntW-1:0] csum_digits;
  logic [SumW-1:0]     csum_acc;
  logic [MsgCntW-1:0]  digit_idx;

  chain_digit_t expected_digits[$];
  int unsigned  failures;

  // Split one byte into digits, most significant first, and append the
  // checksum digits once the message count is reached.
  task automatic split_byte(input logic [ByteW-1:0] b);
    int unsigned  lg;
    int unsigned  msk;
    int unsigned  md;
    int unsigned  cd;
    int unsigned  bits;
    int unsigned  sh;
    int unsigned  d;
    chain_digit_t r;
    lg   = 1 << width_sel;
    msk  = (1 << lg) - 1;
    md   = msg_digits;
    cd   = csum_digits;
    bits = 8;
    if (md < 1) md = 1;
    if (md > MAX_MESSAGE_DIGITS) md = MAX_MESSAGE_DIGITS;
    if (cd < 1) cd = 1;
    if (cd > MaxCsumDig) cd = MaxCsumDig;

    // Message digits; bits left over after the last one are dropped.
    while (bits >= lg && digit_idx < md) begin
      bits          -= lg;
      d              = (b >> bits) & msk;
      r.digit        = ByteW'(d);
      r.position     = digit_idx;
      r.is_checksum  = 1'b0;
      r.last         = 1'b0;
      expected_digits.push_back(r);
      csum_acc       = csum_acc + SumW'(msk - d);
      digit_idx      = digit_idx + 1'b1;
    end

    // Checksum digits, most significant first; digits above the sum are 0.
    if (digit_idx >= md) begin
      for (int unsigned i = 0; i < cd; i++) begin
        sh            = cd * lg - (i + 1) * lg;
        d             = (sh >= SumW) ? 0 : ((csum_acc >> sh) & msk);
        r.digit       = ByteW'(d);
        r.position    = MsgCntW'(md + i);
        r.is_checksum = 1'b1;
        r.last        = (i + 1 == cd);
        expected_digits.push_back(r);
      end
      csum_acc  = '0;
      digit_idx = '0;
    end
  endtask

  // Track register writes, check result beats, then predict from new bytes.
  always @(posedge clk_i or negedge rst_ni) begin
    chain_digit_t got;
    chain_digit_t want;
    if (!rst_ni) begin
      width_sel   = WidthSelRst;
      msg_digits  = MsgDigitsRst;
      csum_digits = CsumDigitsRst;
      csum_acc    = '0;
      digit_idx   = '0;
      failures    = 0;
      expected_digits.delete();
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_WIDTH_SEL:   width_sel   = cfg_data_i[SelW-1:0];
          CFG_MSG_DIGITS:  msg_digits  = cfg_data_i[MsgCntW-1:0];
          CFG_CSUM_DIGITS: csum_digits = cfg_data_i[CsumCntW-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        got.digit       = digit_i;
        got.position    = position_i;
        got.is_checksum = is_checksum_i;
        got.last        = last_i;
        if (expected_digits.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: unexpected result beat: digit %0d pos %0d csum %0b last %0b",
                     $time, got.digit, got.position, got.is_checksum, got.last);
          end
        end else begin
          want = expected_digits.pop_front();
          if (got.digit !== want.digit || got.position !== want.position ||
              got.is_checksum !== want.is_checksum || got.last !== want.last) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: mismatch: expected digit %0d pos %0d csum %0b last %0b",
                       $time, want.digit, want.position, want.is_checksum, want.last);
              $display("%0t:          got      digit %0d pos %0d csum %0b last %0b",
                       $time, got.digit, got.position, got.is_checksum, got.last);
            end
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        split_byte(msg_byte_i);
      end

      pending_o        <= expected_digits.size();
      mismatch_count_o <= failures;
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives message bytes and register writes into the base-w digit splitter,
// first a directed set of corner cases, then random phases with random
// settings, bursty bytes and a stalling receiver; the checker beside the
// block predicts and compares every digit beat.
// ----------------------------------------------------------------------------
module tb;
  import wbcd_pkg::*;

  localparam int unsigned MaxMsgDigits = MaxMessageDigitsDef;
  localparam int unsigned TargetItems  = 410;
  localparam int unsigned QuietLimit   = 2000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ByteW-1:0]    msg_byte_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ByteW-1:0]    digit_o;
  logic [MsgCntW-1:0]  position_o;
  logic                is_checksum_o;
  logic                last_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int unsigned mismatch_count;
  int unsigned digits_pending;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned quiet_count = 0;
  int unsigned stall_span  = 0;
  int unsigned stall_mode  = 0;

  wots_base_w_checksum_digits_top #(
    .MAX_MESSAGE_DIGITS(MaxMsgDigits)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .msg_byte_i    (msg_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digit_o       (digit_o),
    .position_o    (position_o),
    .is_checksum_o (is_checksum_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  wbcd_digit_checker #(
    .MAX_MESSAGE_DIGITS(MaxMsgDigits)
  ) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .msg_byte_i       (msg_byte_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digit_i          (digit_o),
    .position_i       (position_o),
    .is_checksum_i    (is_checksum_o),
    .last_i           (last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (digits_pending)
  );

  always #5 clk_i = ~clk_i;

  // The receiver switches between stall patterns at random intervals.
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(16, 120);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ~out_stall_i;
    endcase
  end

  // Ends the run if no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // Holds one register write until it is taken; valid is lowered by the caller.
  task automatic write_reg(input wbcd_cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(input logic [CfgDataW-1:0] sel, input logic [CfgDataW-1:0] md,
                           input logic [CfgDataW-1:0] cd);
    write_reg(CFG_WIDTH_SEL, sel);
    write_reg(CFG_MSG_DIGITS, md);
    write_reg(CFG_CSUM_DIGITS, cd);
    cfg_valid_i <= 1'b0;
  endtask

  // Sends one byte beat; bursts of random length are separated by random gaps.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    msg_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Stops sending and waits until every awaited digit has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (digits_pending != 0);
  endtask

  initial begin
    int unsigned       sel;
    int unsigned       md;
    int unsigned       cd;
    int unsigned       phase_len;
    logic [ByteW-1:0]  b;
    bit                first_phase;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    msg_byte_i  = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_WIDTH_SEL;
    cfg_data_i  = '0;
    first_phase = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, left in the middle of a message.
    send_byte(8'h3C);
    send_byte(8'hC3);
    wait_drained();
    // Counts of zero clamp to one; the counter is already past the count.
    configure(10'd3, 10'd0, 10'd0);
    send_byte(8'hFF);
    send_byte(8'h00);
    wait_drained();
    // Low nibble of the second byte is dropped; wide checksum with zero digits.
    configure(10'd2, 10'd3, 10'd16);
    send_byte(8'h12);
    send_byte(8'h34);
    wait_drained();
    // Oversized counts clamp; the message is then cut short by a smaller count.
    configure(10'd0, 10'd1023, 10'd31);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'hFF);
    wait_drained();
    configure(10'd0, 10'd10, 10'd2);
    send_byte(8'h00);
    wait_drained();
    // Digit width changes in the middle of a message.
    configure(10'd2, 10'd8, 10'd3);
    send_byte(8'hC3);
    wait_drained();
    configure(10'd0, 10'd8, 10'd3);
    send_byte(8'h96);
    wait_drained();
    configure(10'd1, 10'd4, 10'd16);
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_drained();
    configure(10'd3, 10'd2, 10'd5);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(8'hFE);
    wait_drained();

    // Random phases; the first one runs a full message at the largest count.
    while (items_sent < TargetItems) begin
      if (first_phase) begin
        sel         = 0;
        md          = 1023;
        cd          = 31;
        phase_len   = 70;
        first_phase = 1'b0;
      end else begin
        sel = $urandom_range(0, 3);
        case ($urandom_range(0, 9))
          0:       md = 0;
          1:       md = $urandom_range(513, 1023);
          default: md = $urandom_range(1, (8 >> sel) * $urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 7))
          0:       cd = 0;
          1:       cd = $urandom_range(17, 31);
          default: cd = $urandom_range(1, 16);
        endcase
        phase_len = $urandom_range(8, 50);
      end
      configure(CfgDataW'(sel), CfgDataW'(md), CfgDataW'(cd));
      repeat (phase_len) begin
        if ($urandom_range(0, 39) == 0) begin
          wait_drained();
        end
        case ($urandom_range(0, 7))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = ByteW'($urandom_range(0, 255));
        endcase
        send_byte(b);
      end
      wait_drained();
    end

    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && digits_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
